>>> rtl/dhrst_pkg.sv
package dhrst_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 152;
   localparam int WINDOW_W   = 16;
   localparam int INDEX_W    = 6;

   localparam logic [15:0] ETH_IPV4      = 16'h0800;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] SERVER_PORT   = 16'd67;
   localparam logic [7:0]  DHCP_OP_REPLY = 8'd2;
   localparam logic [15:0] WINDOW_RESET  = 16'd10;

   localparam logic [1:0] MARK_UNKNOWN = 2'd2;

   localparam logic OPER_FRAME = 1'b0;
   localparam logic OPER_SWEEP = 1'b1;

   typedef struct packed {
      logic load;
      logic run;
      logic insert;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic req_go;
      logic sweep;
      logic hit;
      logic done;
      logic hold_vld;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic               online;
      logic [47:0]        station_mac;
      logic [31:0]        station_ip;
      logic [31:0]        last_seen;
      logic [31:0]        since_report;
   } result_type;

   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] ip;
      logic [31:0] seen;
   } slot_type;

   typedef struct packed {
      logic [1:0]  mark;
      logic [31:0] rtime;
   } rep_type;

endpackage

>>> rtl/dhrst_ctrl.sv
module dhrst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  dhrst_pkg::status_type status,
   output dhrst_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_FLUSH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.req_go) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.run = 1'b1;
            if (status.hit) begin
               state_in = S_IDLE;
            end else if (status.done) begin
               if (status.sweep) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.insert = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (!status.hold_vld || status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/dhrst_dp.sv
module dhrst_dp #(
   parameter int TABLE_ENTRIES = dhrst_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dhrst_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dhrst_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [dhrst_pkg::WINDOW_W-1:0]      csr_wdata,
   input  dhrst_pkg::cmd_type                  cmd,
   output dhrst_pkg::status_type               status
);

   localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = IW + 1;
   localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_ENTRIES);

   logic [31:0] req_now;
   logic [47:0] req_mac;
   logic [15:0] req_ether;
   logic [7:0]  req_proto;
   logic [31:0] req_ip;
   logic [15:0] req_port;
   logic [7:0]  req_op;
   logic        req_force;
   logic        req_pass;

   assign req_now   = req_tdata[31:0];
   assign req_mac   = req_tdata[79:32];
   assign req_ether = req_tdata[95:80];
   assign req_proto = req_tdata[103:96];
   assign req_ip    = req_tdata[135:104];
   assign req_port  = req_tdata[151:136];
   assign req_op    = req_tdata[159:152];
   assign req_force = req_tdata[160];

   assign req_pass = (req_ether == dhrst_pkg::ETH_IPV4) && (req_proto == dhrst_pkg::PROTO_UDP) &&
                     (req_port == dhrst_pkg::SERVER_PORT) &&
                     (req_op == dhrst_pkg::DHCP_OP_REPLY);

   logic [dhrst_pkg::WINDOW_W-1:0] win_ff;
   logic        op_ff;
   logic [31:0] now_ff;
   logic [47:0] mac_ff;
   logic [31:0] ip_ff;
   logic        force_ff;

   dhrst_pkg::slot_type slot_mem [TABLE_ENTRIES];
   dhrst_pkg::rep_type  rep_mem  [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] rinit_ff;

   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic             s1_vld_ff;
   logic             s1_vld_in;
   logic [IW-1:0]    s1_idx_ff;
   logic             s1_slot_valid_ff;
   logic             s1_rinit_ff;
   dhrst_pkg::slot_type q_slot_ff;
   dhrst_pkg::rep_type  q_rep_ff;

   logic             free_found_ff;
   logic             free_found_in;
   logic [IW-1:0]    free_idx_ff;

   logic                  hold_vld_ff;
   logic                  hold_vld_in;
   dhrst_pkg::result_type hold_ff;
   logic                  out_vld_ff;
   logic                  out_vld_in;
   dhrst_pkg::result_type out_ff;
   logic                  out_last_ff;

   logic        out_free;
   logic        advance;
   logic        issue;
   logic        hit;
   logic        rep_chk;
   logic [1:0]  cur_mark;
   logic [31:0] cur_time;
   logic [32:0] limit;
   logic        online;
   logic        report;
   logic        stall;
   logic        rpt_take;
   logic        flush_emit;
   logic        slot_wr;
   logic [IW-1:0] slot_waddr;
   logic [IW+5:0] index_ext;
   dhrst_pkg::result_type new_res;

   assign out_free = !out_vld_ff || rsp_tready;

   assign cur_mark = s1_rinit_ff ? q_rep_ff.mark : dhrst_pkg::MARK_UNKNOWN;
   assign cur_time = s1_rinit_ff ? q_rep_ff.rtime : 32'd0;
   assign limit    = {1'b0, q_slot_ff.seen} + 33'(win_ff);
   assign online   = (limit >= {1'b0, now_ff});

   assign rep_chk = cmd.run && s1_vld_ff && (op_ff == dhrst_pkg::OPER_SWEEP) && s1_slot_valid_ff;
   assign report  = rep_chk && (force_ff || ({1'b0, online} != cur_mark));
   assign stall   = report && hold_vld_ff && !out_free;
   assign advance = cmd.run && !stall;
   assign issue   = advance && (idx_ff < N_CNT);
   assign rpt_take = report && !stall;

   assign hit = cmd.run && s1_vld_ff && (op_ff == dhrst_pkg::OPER_FRAME) && s1_slot_valid_ff &&
                (q_slot_ff.mac == mac_ff);

   assign flush_emit = cmd.flush && hold_vld_ff && out_free;

   assign slot_wr    = hit || (cmd.insert && free_found_ff);
   assign slot_waddr = hit ? s1_idx_ff : free_idx_ff;

   assign index_ext = {{6{1'b0}}, s1_idx_ff};

   always_comb begin
      new_res              = '0;
      new_res.entry_index  = index_ext[5:0];
      new_res.online       = online;
      new_res.station_mac  = q_slot_ff.mac;
      new_res.station_ip   = q_slot_ff.ip;
      new_res.last_seen    = q_slot_ff.seen;
      new_res.since_report = q_slot_ff.seen - cur_time;
   end

   always_comb begin
      idx_in = idx_ff;
      s1_vld_in = s1_vld_ff;
      if (cmd.load) begin
         idx_in    = '0;
         s1_vld_in = 1'b0;
      end else if (advance) begin
         s1_vld_in = issue;
         if (issue) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      free_found_in = free_found_ff;
      if (cmd.load) begin
         free_found_in = 1'b0;
      end else if (cmd.run && s1_vld_ff && !s1_slot_valid_ff) begin
         free_found_in = 1'b1;
      end
   end

   always_comb begin
      hold_vld_in = hold_vld_ff;
      out_vld_in  = out_vld_ff;
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      if (flush_emit) begin
         hold_vld_in = 1'b0;
         out_vld_in  = 1'b1;
      end else if (rpt_take) begin
         hold_vld_in = 1'b1;
         if (hold_vld_ff) begin
            out_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= dhrst_pkg::WINDOW_RESET;
         idx_ff        <= '0;
         s1_vld_ff     <= 1'b0;
         free_found_ff <= 1'b0;
         hold_vld_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         rinit_ff      <= '0;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         idx_ff        <= idx_in;
         s1_vld_ff     <= s1_vld_in;
         free_found_ff <= free_found_in;
         hold_vld_ff   <= hold_vld_in;
         out_vld_ff    <= out_vld_in;
         if (cmd.insert && free_found_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (rpt_take) begin
            rinit_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         now_ff   <= req_now;
         mac_ff   <= req_mac;
         ip_ff    <= req_ip;
         force_ff <= req_force;
      end
      if (issue) begin
         s1_idx_ff        <= idx_ff[IW-1:0];
         s1_slot_valid_ff <= valid_ff[idx_ff[IW-1:0]];
         s1_rinit_ff      <= rinit_ff[idx_ff[IW-1:0]];
      end
      if (cmd.run && s1_vld_ff && !s1_slot_valid_ff && !free_found_ff) begin
         free_idx_ff <= s1_idx_ff;
      end
      if (flush_emit) begin
         out_ff      <= hold_ff;
         out_last_ff <= 1'b1;
      end else if (rpt_take) begin
         hold_ff <= new_res;
         if (hold_vld_ff) begin
            out_ff      <= hold_ff;
            out_last_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         q_slot_ff <= slot_mem[idx_ff[IW-1:0]];
      end
      if (slot_wr) begin
         slot_mem[slot_waddr] <= '{mac: mac_ff, ip: ip_ff, seen: now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         q_rep_ff <= rep_mem[idx_ff[IW-1:0]];
      end
      if (rpt_take) begin
         rep_mem[s1_idx_ff] <= '{mark: {1'b0, online}, rtime: q_slot_ff.seen};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_ff.since_report, out_ff.last_seen, out_ff.station_ip,
                        out_ff.station_mac, out_ff.online, out_ff.entry_index};

   assign status.req_go   = (req_tuser == dhrst_pkg::OPER_SWEEP) || req_pass;
   assign status.sweep    = (op_ff == dhrst_pkg::OPER_SWEEP);
   assign status.hit      = hit;
   assign status.done     = (idx_ff == N_CNT) && !s1_vld_ff;
   assign status.hold_vld = hold_vld_ff;
   assign status.out_free = out_free;

endmodule

>>> rtl/dhcp_reply_station_table.sv
// A frame request walks the table one slot per cycle and ends early when its MAC is found;
// a frame that fails the header checks is accepted and dropped without a walk.
// A sweep request walks every slot but stalls while the result side cannot take a report,
// and its final result, if any, is sent with rsp_tlast set.
// Synchronous reset empties the table, marks every report state unknown with time zero,
// and sets the online window to 10 seconds; the rate is set by one read port per memory.
module dhcp_reply_station_table #(
   parameter int TABLE_ENTRIES = dhrst_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_seconds, source_mac, eth_type, ip_protocol, ip_source, udp_source_port,
   // dhcp_op, force_all, zero padding
   input  logic [dhrst_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // entry_index, online, station_mac, station_ip, last_seen, since_report, zero padding
   output logic [dhrst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [dhrst_pkg::WINDOW_W-1:0]   csr_wdata
);

   dhrst_pkg::cmd_type    cmd;
   dhrst_pkg::status_type status;

   dhrst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dhrst_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
